@@ hw/rtl/twiddle_gain_tuner_defines.svh @@
// Assertion macros shared by the twiddle gain tuner checker.
`ifndef TWIDDLE_GAIN_TUNER_DEFINES_SVH
`define TWIDDLE_GAIN_TUNER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define TGT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("twiddle_gain_tuner: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define TGT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("twiddle_gain_tuner: next-cycle check failed");

`endif

@@ hw/rtl/tgt_pkg.sv @@
// Types, constants and arithmetic helpers of the twiddle gain tuner.
`default_nettype none

package tgt_pkg;

	localparam int NUM_GAINS = 3;
	localparam int IDX_W     = 2;
	localparam int GAIN_W    = 32;
	localparam int ERR_W     = 16;
	localparam int SUM_W     = 48;

	// request codes
	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_UPDATE = 1'b1;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_INIT_P = 2'd0;
	localparam logic [IDX_W-1:0] REG_INIT_I = 2'd1;
	localparam logic [IDX_W-1:0] REG_INIT_D = 2'd2;

	localparam logic [IDX_W-1:0] INDEX_RESET = 2'd2;

	// reciprocal of ten: floor(m * 0xCCCCCCCD / 2^35) == floor(m / 10) for any 32-bit m
	localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
	localparam int          DIV10_SHIFT = 35;

	typedef struct packed {
		logic                    req_type;
		logic signed [ERR_W-1:0] error_sample;
	} tgt_in_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0] gain_p;
		logic signed [GAIN_W-1:0] gain_i;
		logic signed [GAIN_W-1:0] gain_d;
		logic [IDX_W-1:0]         tuned_index;
	} tgt_out_t;

	// Move to the next gain, wrapping after the last one.
	function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] idx);
		if (32'(idx) >= NUM_GAINS - 1) begin
			return '0;
		end
		return idx + 1'b1;
	endfunction

	// Signed division by ten, truncated toward zero.
	function automatic logic signed [GAIN_W-1:0] div10_trunc(input logic signed [GAIN_W-1:0] v);
		logic [GAIN_W-1:0]   mag;
		logic [2*GAIN_W-1:0] prod;
		logic [GAIN_W-1:0]   quo;
		mag  = v[GAIN_W-1] ? (~v + 32'd1) : v;
		prod = {32'd0, mag} * {32'd0, DIV10_MAGIC};
		quo  = GAIN_W'(prod[2*GAIN_W-1:DIV10_SHIFT]);
		return v[GAIN_W-1] ? (~quo + 32'd1) : quo;
	endfunction

	// Clamp a 34-bit signed value to the signed 32-bit range.
	function automatic logic signed [GAIN_W-1:0] sat32(input logic signed [GAIN_W+1:0] x);
		if (x[GAIN_W+1:GAIN_W-1] == 3'b000 || x[GAIN_W+1:GAIN_W-1] == 3'b111) begin
			return x[GAIN_W-1:0];
		end
		return x[GAIN_W+1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/twiddle_gain_tuner.sv @@
// Twiddle (coordinate descent) tuner for three signed Q16.16 PID gains.
//
// Input channel (in_valid / in_stall / in_word): a sample word (req_type 0)
// squares its Q8.8 error and adds it to a saturating 48-bit error sum; an
// update word (req_type 1) runs one twiddle step on the gain being tuned.
// Output channel (out_valid / out_stall / out_word): one word per input word
// with the three gains and the index being tuned after that word.
// Config port: cfg_we with cfg_index 0..2 loads P, I or D and sets its step
// to a tenth of the value; other indexes are ignored. Write only when idle.
// Results: out_valid rises once the word has passed the input register and
// then the state register that also drives the result word.
// Throughput: one word per cycle while no result is held by out_stall; each
// update is worked out combinationally by the divide-by-ten multiplier and
// its remainder fix-up in front of the step registers.
// Reset clears the gains and steps, the error sum, probe flags and output
// valid, sets the best sum to all ones and the tuned index to two.
// While out_stall holds a result, one more word is taken into the input
// register; after that in_stall rises until the result is taken.
`default_nettype none

module twiddle_gain_tuner import tgt_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire tgt_in_t                  in_word,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output tgt_out_t                      out_word,
	input  wire logic                     cfg_we,
	input  wire logic [IDX_W-1:0]         cfg_index,
	input  wire logic signed [GAIN_W-1:0] cfg_data
);

	// tuner state
	logic signed [GAIN_W-1:0] gains_q [NUM_GAINS];
	logic signed [GAIN_W-1:0] steps_q [NUM_GAINS];
	logic [SUM_W-1:0]         error_sum_q;
	logic [SUM_W-1:0]         best_sum_q;
	logic [IDX_W-1:0]         index_q;
	logic                     tried_up_q;
	logic                     tried_down_q;
	logic                     first_done_q;

	// handshake
	logic    valid_s1;
	tgt_in_t word_s1;
	logic    out_valid_q;
	logic    accept;
	logic    advance;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= in_word;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// update datapath
	logic [IDX_W-1:0]         cur;
	logic [IDX_W-1:0]         sel;
	logic [IDX_W-1:0]         index_new;
	logic signed [GAIN_W-1:0] step_cur;
	logic signed [GAIN_W-1:0] step_sel;
	logic signed [GAIN_W-1:0] gain_sel;
	logic signed [GAIN_W-1:0] step_tenth;
	logic signed [GAIN_W-1:0] step_rem;
	logic signed [GAIN_W-1:0] step_tenth_up;
	logic signed [GAIN_W-1:0] step_grown;
	logic signed [GAIN_W-1:0] step_shrunk;
	logic signed [GAIN_W-1:0] gain_new;
	logic                     improved;
	logic                     tu_eff;
	logic                     td_eff;
	logic                     probe_up;
	logic                     probe_down;
	logic                     restore;
	logic                     grow;

	always_comb begin
		cur = (32'(index_q) >= NUM_GAINS) ? '0 : index_q;
		improved = error_sum_q < best_sum_q;
		sel = improved ? next_index(cur) : cur;

		// pick lanes by index
		step_cur = '0;
		step_sel = '0;
		gain_sel = '0;
		for (int k = 0; k < NUM_GAINS; k++) begin
			if (cur == IDX_W'(k)) begin
				step_cur = steps_q[k];
			end
			if (sel == IDX_W'(k)) begin
				step_sel = steps_q[k];
				gain_sel = gains_q[k];
			end
		end

		// step scaling by 1.1 and 0.9; for 0.9 the tenth rounds away from
		// zero so that the product still truncates toward zero
		step_tenth    = div10_trunc(step_cur);
		step_rem      = step_cur - ((step_tenth <<< 3) + (step_tenth <<< 1));
		step_tenth_up = (step_rem == '0) ? step_tenth :
			(step_cur[GAIN_W-1] ? step_tenth - 32'sd1 : step_tenth + 32'sd1);
		step_grown    = sat32(34'(step_cur) + 34'(step_tenth));
		step_shrunk   = step_cur - step_tenth_up;

		// probe sequence: up, down by two, then restore
		tu_eff     = !improved && tried_up_q;
		td_eff     = !improved && tried_down_q;
		probe_up   = !tu_eff && !td_eff;
		probe_down = tu_eff && !td_eff;
		restore    = !probe_up && !probe_down;
		grow       = improved && first_done_q;

		if (probe_down) begin
			gain_new = sat32(34'(gain_sel) - (34'(step_sel) <<< 1));
		end else begin
			gain_new = sat32(34'(gain_sel) + 34'(step_sel));
		end
		index_new = restore ? next_index(sel) : sel;
	end

	// sample datapath
	logic [2*ERR_W-1:0] err_sq;
	logic [SUM_W:0]     sum_wide;
	logic [SUM_W-1:0]   sum_new;

	assign err_sq   = 32'(word_s1.error_sample * word_s1.error_sample);
	assign sum_wide = {1'b0, error_sum_q} + (SUM_W+1)'(err_sq);
	assign sum_new  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q  <= '0;
			best_sum_q   <= '1;
			index_q      <= INDEX_RESET;
			tried_up_q   <= 1'b0;
			tried_down_q <= 1'b0;
			first_done_q <= 1'b0;
		end else if (advance) begin
			if (word_s1.req_type == REQ_UPDATE) begin
				if (improved) begin
					best_sum_q <= error_sum_q;
				end
				error_sum_q  <= '0;
				index_q      <= index_new;
				tried_up_q   <= probe_up || probe_down;
				tried_down_q <= probe_down;
				first_done_q <= 1'b1;
			end else begin
				error_sum_q <= sum_new;
			end
		end
	end

	// gain and step lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_GAINS; k++) begin
				gains_q[k] <= '0;
				steps_q[k] <= '0;
			end
		end else begin
			for (int k = 0; k < NUM_GAINS; k++) begin
				if (cfg_we && cfg_index == IDX_W'(k)) begin
					gains_q[k] <= cfg_data;
					steps_q[k] <= div10_trunc(cfg_data);
				end else if (advance && word_s1.req_type == REQ_UPDATE) begin
					if (sel == IDX_W'(k)) begin
						gains_q[k] <= gain_new;
					end
					if (grow && cur == IDX_W'(k)) begin
						steps_q[k] <= step_grown;
					end else if (restore && cur == IDX_W'(k)) begin
						steps_q[k] <= step_shrunk;
					end
				end
			end
		end
	end

	// result word straight from the state, held while stalled
	assign out_valid            = out_valid_q;
	assign out_word.gain_p      = gains_q[REG_INIT_P];
	assign out_word.gain_i      = gains_q[REG_INIT_I];
	assign out_word.gain_d      = gains_q[REG_INIT_D];
	assign out_word.tuned_index = index_q;

endmodule

`default_nettype wire

@@ hw/rtl/tgt_checker.sv @@
// Port-level checks of the twiddle gain tuner and their bind.
`default_nettype none

`include "twiddle_gain_tuner_defines.svh"

module tgt_checker import tgt_pkg::*; (
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     in_valid,
	input wire logic     in_stall,
	input wire tgt_in_t  in_word,
	input wire logic     out_valid,
	input wire logic     out_stall,
	input wire tgt_out_t out_word
);

	// a held result stays put
	`TGT_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))

	// input only backs up behind a stalled result
	`TGT_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall)

	// a fresh result traces back to an accepted word, through the input and state registers
	`TGT_ASSERT_IMP(a_out_origin, $rose(out_valid), $past(in_valid && !in_stall, 2))

	// tuned index stays on a real gain
	`TGT_ASSERT_IMP(a_index_range, out_valid, out_word.tuned_index != 2'd3)

endmodule

bind twiddle_gain_tuner tgt_checker u_tgt_checker (.*);

`default_nettype wire
